// ----- hw/rtl/stl_pkg.sv -----
package stl_pkg;

    // scan modes
    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_COMMENT = 3'd1;
    localparam logic [2:0] M_IDENT   = 3'd2;
    localparam logic [2:0] M_INT     = 3'd3;
    localparam logic [2:0] M_DOT     = 3'd4;
    localparam logic [2:0] M_FRAC    = 3'd5;
    localparam logic [2:0] M_STRING  = 3'd6;
    localparam logic [2:0] M_OP      = 3'd7;

    // token kinds
    localparam logic [5:0] K_DOT    = 6'd8;
    localparam logic [5:0] K_IDENT  = 6'd21;
    localparam logic [5:0] K_STRING = 6'd22;
    localparam logic [5:0] K_NUMBER = 6'd23;
    localparam logic [5:0] K_ERROR  = 6'd37;
    localparam logic [5:0] K_END    = 6'd38;
    localparam logic [5:0] K_NONE   = 6'd63;

    // error codes
    localparam logic [1:0] E_NONE   = 2'd0;
    localparam logic [1:0] E_STRING = 2'd1;
    localparam logic [1:0] E_CHAR   = 2'd2;

    // fixed field widths
    localparam int unsigned OFF_W  = 24;
    localparam int unsigned LINE_W = 20;

    // token kind numbers for '(' ... '*', K_NONE when not a punctuator
    function automatic logic [5:0] punct_kind(input logic [7:0] c);
        logic [5:0] k;
        begin
            unique case (c)
                8'h28:   k = 6'd0;
                8'h29:   k = 6'd1;
                8'h5B:   k = 6'd2;
                8'h5D:   k = 6'd3;
                8'h7B:   k = 6'd4;
                8'h7D:   k = 6'd5;
                8'h3B:   k = 6'd6;
                8'h2C:   k = 6'd7;
                8'h2E:   k = 6'd8;
                8'h2D:   k = 6'd9;
                8'h2B:   k = 6'd10;
                8'h2F:   k = 6'd11;
                8'h2A:   k = 6'd12;
                default: k = K_NONE;
            endcase
            return k;
        end
    endfunction

    function automatic logic [5:0] op_base(input logic [7:0] c);
        logic [5:0] k;
        begin
            unique case (c)
                8'h21:   k = 6'd13;
                8'h3D:   k = 6'd15;
                8'h3E:   k = 6'd17;
                default: k = 6'd19;
            endcase
            return k;
        end
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // one token as it travels from front to back
    typedef struct packed {
        logic [5:0]        kind;
        logic [OFF_W-1:0]  start;
        logic [OFF_W-1:0]  length;
        logic [LINE_W-1:0] line;
        logic [1:0]        err;
        logic              last;
    } token_t;

    // up to three tokens caused by one byte
    typedef struct packed {
        logic [1:0] count;
        token_t     t0;
        token_t     t1;
        token_t     t2;
    } group_t;

endpackage

// ----- hw/rtl/stl_scan.sv -----
module stl_scan #(
    parameter int unsigned KEYWORD_MAX_LEN = 10
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic [7:0]      c_in,
    input  logic            fin_in,
    output stl_pkg::group_t grp
);

    localparam int unsigned OFFSET_BITS = stl_pkg::OFF_W;
    localparam int unsigned LINE_BITS   = stl_pkg::LINE_W;
    localparam int unsigned KLW = $clog2(KEYWORD_MAX_LEN + 2);
    localparam int unsigned KIW = $clog2(KEYWORD_MAX_LEN);
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

    logic [2:0]             mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] begin_reg, begin_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [7:0]             pend_reg, pend_next;
    logic [KLW-1:0]         wlen_reg, wlen_next;
    logic [7:0]             prefix_reg [KEYWORD_MAX_LEN];

    logic                   wr_en;
    logic [KIW-1:0]         wr_idx;

    // keyword lookup over the stored prefix
    function automatic logic match(input logic [79:0] kw, input int unsigned n,
                                   input logic [7:0] p [KEYWORD_MAX_LEN]);
        logic ok;
        begin
            ok = 1'b1;
            for (int i = 0; i < 10; i++)
                if (i < n && p[i] != kw[(9-i)*8 +: 8])
                    ok = 1'b0;
            return ok;
        end
    endfunction

    logic [5:0] word_kind;
    always_comb
    begin
        word_kind = stl_pkg::K_IDENT;
        if (32'(wlen_reg) <= KEYWORD_MAX_LEN)
        begin
            priority if (wlen_reg == KLW'(3) && match({"dhe", 56'd0}, 3, prefix_reg))
                word_kind = 6'd24;
            else if (wlen_reg == KLW'(3) && match({"tip", 56'd0}, 3, prefix_reg))
                word_kind = 6'd25;
            else if (wlen_reg == KLW'(10) && match("perndryshe", 10, prefix_reg))
                word_kind = 6'd26;
            else if (wlen_reg == KLW'(6) && match({"gabuar", 32'd0}, 6, prefix_reg))
                word_kind = 6'd27;
            else if (wlen_reg == KLW'(3) && match({"per", 56'd0}, 3, prefix_reg))
                word_kind = 6'd28;
            else if (wlen_reg == KLW'(8) && match({"funksion", 16'd0}, 8, prefix_reg))
                word_kind = 6'd29;
            else if (wlen_reg == KLW'(4) && match({"nese", 48'd0}, 4, prefix_reg))
                word_kind = 6'd30;
            else if (wlen_reg == KLW'(3) && match({"ose", 56'd0}, 3, prefix_reg))
                word_kind = 6'd31;
            else if (wlen_reg == KLW'(6) && match({"printo", 32'd0}, 6, prefix_reg))
                word_kind = 6'd32;
            else if (wlen_reg == KLW'(4) && match({"kthe", 48'd0}, 4, prefix_reg))
                word_kind = 6'd33;
            else if (wlen_reg == KLW'(6) && match({"vertet", 32'd0}, 6, prefix_reg))
                word_kind = 6'd34;
            else if (wlen_reg == KLW'(6) && match({"shpall", 32'd0}, 6, prefix_reg))
                word_kind = 6'd35;
            else if (wlen_reg == KLW'(6) && match({"derisa", 32'd0}, 6, prefix_reg))
                word_kind = 6'd36;
            else
                word_kind = stl_pkg::K_IDENT;
        end
    end

    // token slots, built then widened
    stl_pkg::token_t tk [3];
    logic [1:0]      n;

    function automatic logic [OFFSET_BITS-1:0] span(input logic [OFFSET_BITS-1:0] a,
                                                    input logic [OFFSET_BITS-1:0] b);
        return (b > a) ? b - a : '0;
    endfunction

    // main classification of one byte
    always_comb
    begin
        logic                   consumed;
        logic                   fl;
        logic [OFFSET_BITS-1:0] dot;
        logic [5:0]             pk;
        logic [OFFSET_BITS-1:0] s_len;
        logic [2:0]             m;
        consumed   = 1'b0;
        fl         = 1'b0;
        dot        = (off_reg != '0) ? off_reg - 1'b1 : '0;
        pk         = stl_pkg::punct_kind(c_in);
        s_len      = '0;
        m          = mode_reg;
        mode_next  = mode_reg;
        begin_next = begin_reg;
        line_next  = line_reg;
        pend_next  = pend_reg;
        wlen_next  = wlen_reg;
        wr_en      = 1'b0;
        wr_idx     = '0;
        off_next   = (off_reg != OFF_MAX) ? off_reg + 1'b1 : off_reg;
        n          = '0;
        for (int i = 0; i < 3; i++)
            tk[i] = '0;

        if (fin_in)
        begin
            fl       = 1'b1;
            off_next = off_reg;
        end
        else
        begin
            unique case (mode_reg)
                stl_pkg::M_IDENT:
                begin
                    if (stl_pkg::is_alpha(c_in) || stl_pkg::is_digit(c_in))
                    begin
                        if (32'(wlen_reg) < KEYWORD_MAX_LEN)
                        begin
                            wr_en  = 1'b1;
                            wr_idx = KIW'(wlen_reg);
                        end
                        if (32'(wlen_reg) <= KEYWORD_MAX_LEN)
                            wlen_next = wlen_reg + 1'b1;
                        consumed = 1'b1;
                    end
                end
                stl_pkg::M_INT:
                begin
                    if (stl_pkg::is_digit(c_in))
                        consumed = 1'b1;
                    else if (c_in == 8'h2E)
                    begin
                        mode_next = stl_pkg::M_DOT;
                        consumed  = 1'b1;
                    end
                end
                stl_pkg::M_DOT, stl_pkg::M_FRAC:
                begin
                    if (stl_pkg::is_digit(c_in))
                    begin
                        mode_next = stl_pkg::M_FRAC;
                        consumed  = 1'b1;
                    end
                end
                stl_pkg::M_STRING:
                begin
                    if (c_in == 8'h22)
                    begin
                        s_len = span(begin_reg, off_reg) + 1'b1;
                        tk[0] = '{stl_pkg::K_STRING, 24'(begin_reg), 24'(s_len),
                                  20'(line_reg), stl_pkg::E_NONE, 1'b0};
                        n = 2'd1;
                        mode_next = stl_pkg::M_IDLE;
                    end
                    else if (c_in == 8'h0A && line_reg != LINE_MAX)
                        line_next = line_reg + 1'b1;
                    consumed = 1'b1;
                end
                stl_pkg::M_OP:
                begin
                    if (c_in == 8'h3D)
                    begin
                        tk[0] = '{stl_pkg::op_base(pend_reg) + 6'd1, 24'(begin_reg), 24'd2,
                                  20'(line_reg), stl_pkg::E_NONE, 1'b0};
                        n = 2'd1;
                        mode_next = stl_pkg::M_IDLE;
                        consumed  = 1'b1;
                    end
                end
                stl_pkg::M_COMMENT:
                begin
                    if (c_in != 8'h0A)
                        consumed = 1'b1;
                    else
                        m = stl_pkg::M_IDLE;
                end
                default:
                    m = stl_pkg::M_IDLE;
            endcase
            fl = !consumed;
        end

        // flush pending token
        if (fl)
        begin
            unique case (m)
                stl_pkg::M_IDENT:
                begin
                    tk[0] = '{word_kind, 24'(begin_reg), 24'(span(begin_reg, off_reg)),
                              20'(line_reg), stl_pkg::E_NONE, 1'b0};
                    n = 2'd1;
                end
                stl_pkg::M_INT, stl_pkg::M_FRAC:
                begin
                    tk[0] = '{stl_pkg::K_NUMBER, 24'(begin_reg),
                              24'(span(begin_reg, off_reg)), 20'(line_reg),
                              stl_pkg::E_NONE, 1'b0};
                    n = 2'd1;
                end
                stl_pkg::M_DOT:
                begin
                    tk[0] = '{stl_pkg::K_NUMBER, 24'(begin_reg), 24'(span(begin_reg, dot)),
                              20'(line_reg), stl_pkg::E_NONE, 1'b0};
                    tk[1] = '{stl_pkg::K_DOT, 24'(dot), 24'd1, 20'(line_reg),
                              stl_pkg::E_NONE, 1'b0};
                    n = 2'd2;
                end
                stl_pkg::M_STRING:
                begin
                    tk[0] = '{stl_pkg::K_ERROR, 24'(begin_reg),
                              24'(span(begin_reg, off_reg)), 20'(line_reg),
                              stl_pkg::E_STRING, 1'b0};
                    n = 2'd1;
                end
                stl_pkg::M_OP:
                begin
                    tk[0] = '{stl_pkg::op_base(pend_reg), 24'(begin_reg), 24'd1,
                              20'(line_reg), stl_pkg::E_NONE, 1'b0};
                    n = 2'd1;
                end
                default:
                    n = '0;
            endcase
            mode_next = stl_pkg::M_IDLE;

            if (fin_in)
            begin
                tk[n] = '{stl_pkg::K_END, 24'(off_reg), 24'd0, 20'(line_reg),
                          stl_pkg::E_NONE, 1'b0};
                n = n + 2'd1;
            end
            else
            begin
                // byte handled between tokens
                priority if (c_in == 8'h20 || c_in == 8'h0D || c_in == 8'h09)
                    n = n;
                else if (c_in == 8'h0A)
                begin
                    if (line_reg != LINE_MAX)
                        line_next = line_reg + 1'b1;
                end
                else if (c_in == 8'h23)
                    mode_next = stl_pkg::M_COMMENT;
                else if (stl_pkg::is_alpha(c_in))
                begin
                    mode_next  = stl_pkg::M_IDENT;
                    begin_next = off_reg;
                    wr_en      = 1'b1;
                    wr_idx     = '0;
                    wlen_next  = KLW'(1);
                end
                else if (stl_pkg::is_digit(c_in))
                begin
                    mode_next  = stl_pkg::M_INT;
                    begin_next = off_reg;
                end
                else if (c_in == 8'h22)
                begin
                    mode_next  = stl_pkg::M_STRING;
                    begin_next = off_reg;
                end
                else if (c_in == 8'h21 || c_in == 8'h3D || c_in == 8'h3C || c_in == 8'h3E)
                begin
                    mode_next  = stl_pkg::M_OP;
                    begin_next = off_reg;
                    pend_next  = c_in;
                end
                else if (pk != stl_pkg::K_NONE)
                begin
                    tk[n] = '{pk, 24'(off_reg), 24'd1, 20'(line_reg), stl_pkg::E_NONE, 1'b0};
                    n = n + 2'd1;
                end
                else
                begin
                    tk[n] = '{stl_pkg::K_ERROR, 24'(off_reg), 24'd1, 20'(line_reg),
                              stl_pkg::E_CHAR, 1'b0};
                    n = n + 2'd1;
                end
            end
        end

        // mark the last token of this beat
        if (n != '0)
            tk[n - 2'd1].last = 1'b1;
    end

    assign grp = '{n, tk[0], tk[1], tk[2]};

    // scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= stl_pkg::M_IDLE;
            begin_reg <= '0;
            off_reg   <= '0;
            line_reg  <= LINE_BITS'(1);
            pend_reg  <= '0;
            wlen_reg  <= '0;
        end
        else if (in_fire)
        begin
            mode_reg  <= mode_next;
            begin_reg <= begin_next;
            off_reg   <= off_next;
            line_reg  <= line_next;
            pend_reg  <= pend_next;
            wlen_reg  <= wlen_next;
        end
    end

    // word prefix store
    always_ff @(posedge clk)
    begin
        if (in_fire && wr_en)
            prefix_reg[wr_idx] <= c_in;
    end

endmodule

// ----- hw/rtl/stl_queue.sv -----
module stl_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  stl_pkg::group_t push_grp,
    output logic            room,
    input  logic            pop,
    output logic            avail,
    output stl_pkg::group_t head
);

    // two entry queue of token groups
    stl_pkg::group_t mem_reg [2];
    logic            wp_reg, rp_reg;
    logic [1:0]      cnt_reg;

    assign room  = (cnt_reg != 2'd2);
    assign avail = (cnt_reg != 2'd0);
    assign head  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_grp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ----- hw/rtl/stl_emit.sv -----
module stl_emit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            avail,
    input  stl_pkg::group_t head,
    output logic            pop,
    output logic            tvalid,
    input  logic            tready,
    output stl_pkg::token_t tok
);

    // walks the tokens of the head group
    logic [1:0] idx_reg;
    stl_pkg::token_t cur;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    cur = head.t0;
            2'd1:    cur = head.t1;
            default: cur = head.t2;
        endcase
    end

    logic is_last;
    assign is_last = (idx_reg + 2'd1 >= head.count);
    assign tvalid  = avail && (head.count != 2'd0);
    assign tok     = cur;
    assign pop     = avail && ((head.count == 2'd0) || (tready && is_last));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else if (pop)
            idx_reg <= 2'd0;
        else if (tvalid && tready)
            idx_reg <= idx_reg + 2'd1;
    end

endmodule

// ----- hw/rtl/source_text_lexer.sv -----
// the tokens of an accepted byte are registered in the group queue, then shown on the master side
// throughput: one byte per cycle when each byte yields at most one token and m_tready is high; a byte
//   yielding two or three tokens holds the output for that many beats
// the front scanner takes one byte per cycle while the two-group queue has room and absorbs bursts
// reset: asynchronous active low, scanner idle, offset zero, line one, queue empty
module source_text_lexer #(
    parameter int unsigned KEYWORD_MAX_LEN = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // token_kind, token_start, token_length, line_number
    output logic [1:0]  m_tuser,   // error_code
    output logic        m_tlast    // last_of_run
);

    stl_pkg::group_t grp, head;
    stl_pkg::token_t tok;
    logic            room, avail, pop, fire;

    assign s_tready = room;
    assign fire     = s_tvalid && room;

    stl_scan #(
        .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_fire(fire),
        .c_in   (s_tdata),
        .fin_in (s_tlast || s_tdata == 8'h00),
        .grp    (grp)
    );

    stl_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fire),
        .push_grp(grp),
        .room    (room),
        .pop     (pop),
        .avail   (avail),
        .head    (head)
    );

    stl_emit u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .avail (avail),
        .head  (head),
        .pop   (pop),
        .tvalid(m_tvalid),
        .tready(m_tready),
        .tok   (tok)
    );

    assign m_tdata = {6'd0, tok.line, tok.length, tok.start, tok.kind};
    assign m_tuser = tok.err;
    assign m_tlast = tok.last;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    typedef struct packed {
        logic [5:0]  kind;
        logic [23:0] start;
        logic [23:0] length;
        logic [19:0] line;
        logic [1:0]  err;
        logic        last;
    } tok_t;

    typedef struct packed {
        logic [7:0] chr;
        logic       fin;
    } beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    source_text_lexer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    beat_t pending_beats[$];
    tok_t  expected_tokens[$];
    int    fail_count;
    int    token_count;
    int    end_count;
    int    quiet_cycles;
    bit    calm;
    bit    stim_done;
    beat_t b_next;

    // lexer state mirror
    logic [2:0]  sc_mode;
    logic [23:0] sc_begin;
    logic [23:0] sc_off;
    logic [19:0] sc_line;
    logic [7:0]  sc_pend;
    logic [7:0]  sc_word[10];
    int          sc_wlen;

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [23:0] span_of(logic [23:0] a, logic [23:0] b);
        return (b > a) ? b - a : 24'd0;
    endfunction

    function automatic logic [5:0] op_kind(logic [7:0] c);
        case (c)
            "!":     return 6'd13;
            "=":     return 6'd15;
            ">":     return 6'd17;
            default: return 6'd19;
        endcase
    endfunction

    function automatic logic [5:0] punct_of(logic [7:0] c);
        case (c)
            "(":     return 6'd0;
            ")":     return 6'd1;
            "[":     return 6'd2;
            "]":     return 6'd3;
            "{":     return 6'd4;
            "}":     return 6'd5;
            ";":     return 6'd6;
            ",":     return 6'd7;
            ".":     return 6'd8;
            "-":     return 6'd9;
            "+":     return 6'd10;
            "/":     return 6'd11;
            "*":     return 6'd12;
            default: return stl_pkg::K_NONE;
        endcase
    endfunction

    function automatic bit letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // keyword lookup on the captured word prefix
    function automatic logic [5:0] word_kind_of();
        string kw[13];
        string w;
        w = "";
        kw = '{"dhe", "tip", "perndryshe", "gabuar", "per", "funksion", "nese", "ose",
               "printo", "kthe", "vertet", "shpall", "derisa"};
        if (sc_wlen > 10) return stl_pkg::K_IDENT;
        for (int i = 0; i < sc_wlen; i++) w = {w, string'(sc_word[i])};
        for (int k = 0; k < 13; k++)
            if (kw[k] == w) return 6'(24 + k);
        return stl_pkg::K_IDENT;
    endfunction

    task automatic emit(ref tok_t run[$], input logic [5:0] k, input logic [23:0] st,
                        input logic [23:0] ln, input logic [1:0] e);
        tok_t t;
        t.kind = k; t.start = st; t.length = ln; t.line = sc_line; t.err = e; t.last = 1'b0;
        if (run.size() < 3) run.push_back(t);
    endtask

    task automatic bump_line();
        if (sc_line != 20'hFFFFF) sc_line++;
    endtask

    task automatic flush_pending(ref tok_t run[$]);
        logic [23:0] dot;
        case (sc_mode)
            stl_pkg::M_IDENT:
                emit(run, word_kind_of(), sc_begin, span_of(sc_begin, sc_off),
                     stl_pkg::E_NONE);
            stl_pkg::M_INT, stl_pkg::M_FRAC:
                emit(run, stl_pkg::K_NUMBER, sc_begin, span_of(sc_begin, sc_off),
                     stl_pkg::E_NONE);
            stl_pkg::M_DOT:
            begin
                dot = (sc_off > 24'd0) ? sc_off - 24'd1 : 24'd0;
                emit(run, stl_pkg::K_NUMBER, sc_begin, span_of(sc_begin, dot),
                     stl_pkg::E_NONE);
                emit(run, stl_pkg::K_DOT, dot, 24'd1, stl_pkg::E_NONE);
            end
            stl_pkg::M_STRING:
                emit(run, stl_pkg::K_ERROR, sc_begin, span_of(sc_begin, sc_off),
                     stl_pkg::E_STRING);
            stl_pkg::M_OP: emit(run, op_kind(sc_pend), sc_begin, 24'd1, stl_pkg::E_NONE);
            default: ;
        endcase
        sc_mode = stl_pkg::M_IDLE;
    endtask

    task automatic start_token(ref tok_t run[$], input logic [7:0] c);
        if (c == " " || c == "\r" || c == "\t") return;
        if (c == "\n") begin bump_line(); return; end
        if (c == "#") begin sc_mode = stl_pkg::M_COMMENT; return; end
        if (letter(c))
        begin
            sc_mode = stl_pkg::M_IDENT; sc_begin = sc_off; sc_word[0] = c; sc_wlen = 1;
        end
        else if (digit(c))
        begin
            sc_mode = stl_pkg::M_INT; sc_begin = sc_off;
        end
        else if (c == "\"")
        begin
            sc_mode = stl_pkg::M_STRING; sc_begin = sc_off;
        end
        else if (c == "!" || c == "=" || c == "<" || c == ">")
        begin
            sc_mode = stl_pkg::M_OP; sc_begin = sc_off; sc_pend = c;
        end
        else if (punct_of(c) != stl_pkg::K_NONE)
            emit(run, punct_of(c), sc_off, 24'd1, stl_pkg::E_NONE);
        else emit(run, stl_pkg::K_ERROR, sc_off, 24'd1, stl_pkg::E_CHAR);
    endtask

    // predict the tokens caused by one accepted beat
    task automatic predict_tokens(input beat_t b);
        tok_t run[$];
        bit   took;
        took = 1'b0;
        if (b.fin || b.chr == 8'd0)
        begin
            flush_pending(run);
            emit(run, stl_pkg::K_END, sc_off, 24'd0, stl_pkg::E_NONE);
        end
        else
        begin
            case (sc_mode)
                stl_pkg::M_IDENT:
                    if (letter(b.chr) || digit(b.chr))
                    begin
                        if (sc_wlen < 10) sc_word[sc_wlen] = b.chr;
                        if (sc_wlen <= 10) sc_wlen++;
                        took = 1'b1;
                    end
                stl_pkg::M_INT:
                    if (digit(b.chr)) took = 1'b1;
                    else if (b.chr == ".") begin sc_mode = stl_pkg::M_DOT; took = 1'b1; end
                stl_pkg::M_DOT, stl_pkg::M_FRAC:
                    if (digit(b.chr)) begin sc_mode = stl_pkg::M_FRAC; took = 1'b1; end
                stl_pkg::M_STRING:
                begin
                    if (b.chr == "\"")
                    begin
                        emit(run, stl_pkg::K_STRING, sc_begin,
                             span_of(sc_begin, sc_off) + 24'd1, stl_pkg::E_NONE);
                        sc_mode = stl_pkg::M_IDLE;
                    end
                    else if (b.chr == "\n") bump_line();
                    took = 1'b1;
                end
                stl_pkg::M_OP:
                    if (b.chr == "=")
                    begin
                        emit(run, op_kind(sc_pend) + 6'd1, sc_begin, 24'd2, stl_pkg::E_NONE);
                        sc_mode = stl_pkg::M_IDLE;
                        took = 1'b1;
                    end
                stl_pkg::M_COMMENT:
                    if (b.chr != "\n") took = 1'b1;
                    else sc_mode = stl_pkg::M_IDLE;
                default: sc_mode = stl_pkg::M_IDLE;
            endcase
            if (!took)
            begin
                flush_pending(run);
                start_token(run, b.chr);
            end
            if (sc_off != 24'hFFFFFF) sc_off++;
        end
        if (run.size() > 0) run[run.size() - 1].last = 1'b1;
        foreach (run[i]) expected_tokens.push_back(run[i]);
    endtask

    task automatic add_text(input string s);
        beat_t b;
        for (int i = 0; i < s.len(); i++)
        begin
            b.chr = s[i]; b.fin = 1'b0;
            pending_beats.push_back(b);
        end
    endtask

    task automatic add_end(input logic [7:0] c);
        beat_t b;
        b.chr = c; b.fin = 1'b1;
        pending_beats.push_back(b);
    endtask

    function automatic string random_piece();
        string frags[24];
        string sym;
        string s;
        frags = '{"dhe ", "tip ", "perndryshe ", "prndryshe ", "gabuar ", "per ",
                  "funksion ", "nese ", "ose ", "printo ", "kthe ", "vertet ",
                  "shpall ", "derisa ", "x_9 ", "perndryshex ", "12.5 ", "7. ",
                  "\"a\nb\" ", "!= ", "<= ", ">= ", "== ", "# note\n"};
        sym = "()[]{};,.-+/*!=<>\n\t\r @";
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: s = frags[$urandom_range(0, 23)];
            6: s = string'(sym[$urandom_range(0, sym.len() - 1)]);
            7: s = string'(byte'($urandom_range(1, 255)));
            8: s = $sformatf("%0d", $urandom_range(0, 99999));
            default: s = "abcdefghijklmnop";
        endcase
        return s;
    endfunction

    // stimulus
    initial
    begin
        beat_t b;
        stim_done = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        // directed
        add_text("dhe tip perndryshe prndryshe gabuar per funksion nese ose printo ");
        add_text("kthe vertet shpall derisa abcdefghijkl 1.x 3.25 ( ) [ ] { } ; , . - + / * ");
        add_text("! != = == > >= < <= !a \"q\nr\" # c\n\t\r");
        b.chr = 8'h80; b.fin = 1'b0; pending_beats.push_back(b);
        b.chr = 8'hFF; pending_beats.push_back(b);
        add_text("@`~ 9.");
        add_end(8'hFF);
        add_text("\"open");
        add_end(8'h00);
        add_text("7");
        b.chr = 8'h00; b.fin = 1'b0; pending_beats.push_back(b);
        // random
        while (pending_beats.size() < 470)
        begin
            add_text(random_piece());
            if ($urandom_range(0, 30) == 0) add_end(8'($urandom));
        end
        add_end(8'h00);
        stim_done = 1'b1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            sc_mode  = stl_pkg::M_IDLE;
            sc_begin = '0;
            sc_off   = '0;
            sc_line  = 20'd1;
            sc_pend  = '0;
            sc_wlen  = 0;
        end
        else
        begin
            if (s_tvalid && s_tready) predict_tokens({s_tdata, s_tlast});
            if ((!s_tvalid || s_tready) && pending_beats.size() > 0 &&
                (calm || $urandom_range(0, 99) >= 37))
            begin
                b_next = pending_beats.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= b_next.chr;
                s_tlast  <= b_next.fin;
            end
            else if (!s_tvalid || s_tready)
                s_tvalid <= 1'b0;
        end
    end

    // receiver readiness, with one long hold-off and a calm stretch
    int rx_cycles;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            rx_cycles <= 0;
            calm      <= 1'b0;
        end
        else
        begin
            rx_cycles <= rx_cycles + 1;
            calm <= (rx_cycles >= 350 && rx_cycles < 550);
            if (rx_cycles >= 200 && rx_cycles < 280) m_tready <= 1'b0;
            else if (rx_cycles >= 350 && rx_cycles < 550) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 99) >= 37);
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        tok_t got;
        tok_t want;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[5:0], m_tdata[29:6], m_tdata[53:30], m_tdata[73:54],
                       m_tuser, m_tlast};
                token_count++;
                if (got.kind == stl_pkg::K_END) end_count++;
                if (expected_tokens.size() == 0)
                begin
                    $display("%0t: unexpected token, expected none, actual %h", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (got.kind != want.kind)
                    begin
                        $display("%0t: kind expected %0d actual %0d", $time, want.kind,
                                 got.kind);
                        fail_count++;
                    end
                    if (got.start != want.start)
                    begin
                        $display("%0t: start expected %0d actual %0d", $time, want.start,
                                 got.start);
                        fail_count++;
                    end
                    if (got.length != want.length)
                    begin
                        $display("%0t: length expected %0d actual %0d", $time, want.length,
                                 got.length);
                        fail_count++;
                    end
                    if (got.line != want.line)
                    begin
                        $display("%0t: line expected %0d actual %0d", $time, want.line,
                                 got.line);
                        fail_count++;
                    end
                    if (got.err != want.err)
                    begin
                        $display("%0t: error expected %0d actual %0d", $time, want.err,
                                 got.err);
                        fail_count++;
                    end
                    if (got.last != want.last)
                    begin
                        $display("%0t: last expected %0d actual %0d", $time, want.last,
                                 got.last);
                        fail_count++;
                    end
                end
            end
        end
        else
            quiet_cycles <= 0;
    end

    // end of run and watchdog
    initial
    begin
        @(posedge rst_n);
        fork
            begin
                wait (stim_done && pending_beats.size() == 0 && !s_tvalid &&
                      expected_tokens.size() == 0);
                repeat (20) @(posedge clk);
                if (expected_tokens.size() != 0)
                    $display("%0t: %0d tokens expected, 0 arrived", $time,
                             expected_tokens.size());
                $display("covered keywords, numbers, strings, operators, comments, errors");
                $display("tokens checked %0d, end tokens %0d", token_count, end_count);
                if (fail_count == 0 && expected_tokens.size() == 0) $display("tb_top: PASS");
                else $display("tb_top: FAIL");
            end
            begin
                wait (quiet_cycles >= 5000);
                $display("%0t: watchdog, no beat moved", $time);
                $display("tb_top: FAIL");
            end
        join_any
        $finish;
    end

endmodule
